@@ src/hkti_pkg.sv @@
// ----------------------------------------------------------------------------
// hkti_pkg
// Shared types, widths and helpers of the knot table interpolator.
// ----------------------------------------------------------------------------
package hkti_pkg;

  localparam int Q_W           = 32;
  localparam int DP_W          = 64;
  localparam int DEF_MAX_KNOTS = 16;

  // shared multiplier geometry
  localparam int MUL_A_W = 60;
  localparam int DIG_W   = 16;
  localparam int N_DIG   = 3;
  localparam int MUL_B_W = DIG_W * N_DIG;
  localparam int PROD_W  = MUL_A_W + DIG_W;
  localparam int ACC_W   = 80;
  localparam int FRAC_W  = 16;

  // delta divider
  localparam int DIV_STEPS = FRAC_W + 1;
  localparam int H_W       = Q_W + 1;
  localparam int REM_W     = Q_W + 2;

  typedef struct packed {
    logic [2:0][Q_W-1:0] slp;
    logic [2:0][Q_W-1:0] val;
    logic [Q_W-1:0]      t;
  } knot_row_t;

  typedef struct packed {
    logic                   go;
    logic signed [DP_W-1:0] a;
    logic signed [DP_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                   done;
    logic signed [DP_W-1:0] p;
  } mul_rsp_t;

  function automatic logic signed [DP_W-1:0] sext32(input logic [Q_W-1:0] x);
    sext32 = {{(DP_W-Q_W){x[Q_W-1]}}, x};
  endfunction

endpackage

@@ src/hkti_mul.sv @@
// ----------------------------------------------------------------------------
// hkti_mul
// Shared Q16.16 multiplier: three 16-bit digits in turn, then rounding.
// ----------------------------------------------------------------------------
module hkti_mul (
  input  logic              clk,
  input  logic              rst,
  input  hkti_pkg::mul_req_t req,
  output hkti_pkg::mul_rsp_t rsp
);
  import hkti_pkg::*;

  logic [MUL_A_W-1:0] ma;
  logic [MUL_B_W-1:0] mb;
  logic               neg;
  logic [ACC_W-1:0]   acc;
  logic [1:0]         cnt;
  logic               run;
  logic               rnd;

  logic [DP_W-1:0]    mag_a;
  logic [DP_W-1:0]    mag_b;
  logic [PROD_W-1:0]  prod;
  logic [ACC_W-1:0]   acc_rnd;
  logic [DP_W-1:0]    r_mag;

  assign mag_a   = req.a[DP_W-1] ? DP_W'(-req.a) : DP_W'(req.a);
  assign mag_b   = req.b[DP_W-1] ? DP_W'(-req.b) : DP_W'(req.b);
  assign prod    = PROD_W'(mb[MUL_B_W-1 -: DIG_W]) * PROD_W'(ma);
  // round half away from zero on the magnitude
  assign acc_rnd = acc + ACC_W'(1 << (FRAC_W - 1));
  assign r_mag   = acc_rnd[FRAC_W +: DP_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      run      <= 1'b0;
      rnd      <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.go) begin
        ma  <= mag_a[MUL_A_W-1:0];
        mb  <= mag_b[MUL_B_W-1:0];
        neg <= req.a[DP_W-1] ^ req.b[DP_W-1];
        acc <= '0;
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        acc <= (acc << DIG_W) + ACC_W'(prod);
        mb  <= mb << DIG_W;
        cnt <= cnt + 2'd1;
        if (cnt == 2'(N_DIG - 1)) begin
          run <= 1'b0;
          rnd <= 1'b1;
        end
      end else if (rnd) begin
        rsp.p    <= neg ? -$signed(r_mag) : $signed(r_mag);
        rsp.done <= 1'b1;
        rnd      <= 1'b0;
      end
    end
  end

endmodule

@@ src/hermite_knot_table_interpolator.sv @@
// ----------------------------------------------------------------------------
// hermite_knot_table_interpolator
// Knot table with a cubic Hermite evaluator on one shared multiplier.
// ----------------------------------------------------------------------------
//  channel   | ports                                   | beat taken when
//  ----------+-----------------------------------------+------------------------
//  request   | start, busy, req_type .. slope_c        | start high, busy low
//  result    | done, result_a .. result_c, status      | done high (one cycle)
//  config    | cfg_we, cfg_wdata                       | cfg_we high
//
// a knot write gives no result beat
// a query inside an interval gives the left knot's stored values when the time
//   equals that knot, else it runs 17 divider steps and 18 passes through the
//   shared multiplier
// a query outside every interval gives status 1 after scanning n intervals
//   (n = clipped interval_count), straight from idle when n is 0
// rst is synchronous; the knot memory is not cleared
// the result beat cannot be stalled; busy stays high until it is shown (never raised when n is 0)
module hermite_knot_table_interpolator #(
  parameter int MAX_KNOTS = hkti_pkg::DEF_MAX_KNOTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [3:0]  knot_index,
  input  logic signed [31:0] time_value,
  input  logic signed [31:0] value_a,
  input  logic signed [31:0] value_b,
  input  logic signed [31:0] value_c,
  input  logic signed [31:0] slope_a,
  input  logic signed [31:0] slope_b,
  input  logic signed [31:0] slope_c,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  output logic        done,
  output logic signed [31:0] result_a,
  output logic signed [31:0] result_b,
  output logic signed [31:0] result_c,
  output logic        status
);
  import hkti_pkg::*;

  localparam int IDX_W = (MAX_KNOTS > 2) ? $clog2(MAX_KNOTS) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_FIRST, S_SCAN, S_DIV, S_ISSUE, S_WAIT
  } state_t;

  state_t state;

  // knot memory, one row per knot
  knot_row_t mem [MAX_KNOTS];
  knot_row_t mem_q;
  knot_row_t wr_row;
  logic [IDX_W-1:0] ra;
  logic             wr_en;

  logic [3:0]       interval_count;
  logic [IDX_W-1:0] n_lim;
  logic [IDX_W-1:0] idx;
  logic signed [Q_W-1:0] tq;
  knot_row_t        row_l;
  knot_row_t        row_r;

  // divider
  logic [H_W-1:0]       h_reg;
  logic [REM_W-1:0]     rem;
  logic [DIV_STEPS-1:0] q;
  logic [4:0]           dcnt;

  // evaluation
  logic [1:0]             comp;
  logic [2:0]             step;
  logic signed [DP_W-1:0] reg_a;
  logic signed [DP_W-1:0] reg_b;
  logic signed [DP_W-1:0] reg_c;
  logic signed [DP_W-1:0] acc;

  mul_req_t mreq;
  mul_rsp_t mrsp;

  hkti_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  // -------------------------------------------------------------- memory
  assign wr_en = start && !busy && !req_type && (32'(knot_index) < 32'(MAX_KNOTS));
  assign wr_row.t   = time_value;
  assign wr_row.val = {value_c, value_b, value_a};
  assign wr_row.slp = {slope_c, slope_b, slope_a};

  always_comb begin
    case (state)
      S_FIRST: ra = IDX_W'(1);
      S_SCAN:  ra = idx + IDX_W'(1);
      default: ra = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[IDX_W'(knot_index)] <= wr_row;
    mem_q <= mem[ra];
  end

  // ------------------------------------------------------- scan compares
  logic signed [Q_W-1:0] t0, t1;
  logic                  hit, hit_eq;
  logic [H_W-1:0]        h_w, diff_w;
  int                    n_clip;

  assign t0     = row_r.t;
  assign t1     = mem_q.t;
  assign hit    = (tq >= t0) && (tq <= t1);
  assign hit_eq = (tq == t0);
  assign h_w    = {t1[Q_W-1], t1} - {t0[Q_W-1], t0};
  assign diff_w = {tq[Q_W-1], tq} - {t0[Q_W-1], t0};
  assign n_clip = (32'(interval_count) > MAX_KNOTS - 1) ? MAX_KNOTS - 1
                                                        : 32'(interval_count);

  // divider step
  logic             div_ge;
  logic [REM_W-1:0] rem_sub;
  assign div_ge  = rem >= REM_W'(h_reg);
  assign rem_sub = div_ge ? rem - REM_W'(h_reg) : rem;

  // -------------------------------------------------- operand selection
  logic signed [DP_W-1:0] y0, y1, d0, d1, dy, delta, hh, p_sat;
  always_comb begin
    y0    = sext32(row_l.val[comp]);
    y1    = sext32(row_r.val[comp]);
    d0    = sext32(row_l.slp[comp]);
    d1    = sext32(row_r.slp[comp]);
    dy    = y0 - y1;
    delta = $signed(DP_W'(q));
    hh    = $signed(DP_W'(h_reg));
    mreq.go = (state == S_ISSUE);
    mreq.b  = (step < 3'd3) ? hh : delta;
    case (step)
      3'd0:    mreq.a = d0 + d1;
      3'd1:    mreq.a = (d0 <<< 1) + d1;
      3'd2:    mreq.a = d0;
      3'd3:    mreq.a = reg_a;
      default: mreq.a = acc;
    endcase
    // final Horner term, saturated to 32 bits
    p_sat = mrsp.p + y0;
    if (p_sat > 64'sh7FFFFFFF)
      p_sat = 64'sh7FFFFFFF;
    else if (p_sat < -64'sh80000000)
      p_sat = -64'sh80000000;
  end

  assign busy = (state != S_IDLE);

  // ----------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      interval_count <= 4'd1;
      done           <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) interval_count <= cfg_wdata;
      case (state)
        S_IDLE: begin
          if (start && req_type) begin
            tq    <= time_value;
            n_lim <= IDX_W'(n_clip);
            if (n_clip == 0) begin
              result_a <= '0;
              result_b <= '0;
              result_c <= '0;
              status   <= 1'b1;
              done     <= 1'b1;
            end else begin
              state <= S_FIRST;
            end
          end
        end
        S_FIRST: begin
          row_r <= mem_q;
          idx   <= IDX_W'(1);
          state <= S_SCAN;
        end
        S_SCAN: begin
          row_l <= row_r;
          row_r <= mem_q;
          if (hit && hit_eq) begin
            // time on the left knot: stored value as is
            result_a <= row_r.val[0];
            result_b <= row_r.val[1];
            result_c <= row_r.val[2];
            status   <= 1'b0;
            done     <= 1'b1;
            state    <= S_IDLE;
          end else if (hit) begin
            h_reg <= h_w;
            rem   <= REM_W'(diff_w);
            q     <= '0;
            dcnt  <= '0;
            state <= S_DIV;
          end else if (idx == n_lim) begin
            result_a <= '0;
            result_b <= '0;
            result_c <= '0;
            status   <= 1'b1;
            done     <= 1'b1;
            state    <= S_IDLE;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_DIV: begin
          rem  <= rem_sub << 1;
          q    <= {q[DIV_STEPS-2:0], div_ge};
          dcnt <= dcnt + 5'd1;
          if (dcnt == 5'(DIV_STEPS - 1)) begin
            comp  <= 2'd0;
            step  <= 3'd0;
            state <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (mrsp.done) begin
            state <= S_ISSUE;
            step  <= step + 3'd1;
            case (step)
              3'd0:    reg_a <= mrsp.p + (dy <<< 1);
              3'd1:    reg_b <= mrsp.p + (dy <<< 1) + dy;
              3'd2:    reg_c <= mrsp.p;
              3'd3:    acc   <= mrsp.p - reg_b;
              3'd4:    acc   <= mrsp.p + reg_c;
              default: begin
                step <= 3'd0;
                comp <= comp + 2'd1;
                case (comp)
                  2'd0:    result_a <= p_sat[Q_W-1:0];
                  2'd1:    result_b <= p_sat[Q_W-1:0];
                  default: begin
                    result_c <= p_sat[Q_W-1:0];
                    status   <= 1'b0;
                    done     <= 1'b1;
                    state    <= S_IDLE;
                  end
                endcase
              end
            endcase
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knot table interpolator testbench
// Loads knot tables, runs queries against a local cubic Hermite predictor
// and compares every result beat with the oldest predicted one.
// ----------------------------------------------------------------------------

class hermite_scoreboard;
  logic signed [31:0] times [16];
  logic signed [31:0] vals [16][3];
  logic signed [31:0] slps [16][3];
  bit   [3:0]         span_count;
  logic [96:0]        pending [$];
  int                 errors;

  function new();
    span_count = 1;
    errors = 0;
  endfunction

  // q16.16 product, round half away from zero, clamp to 2^61
  function automatic logic signed [63:0] qmul(logic signed [63:0] a,
                                              logic signed [63:0] b);
    logic         neg;
    logic [127:0] ua, ub, p;
    logic [127:0] r;
    neg = (a < 0) != (b < 0);
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    p = ua * ub;
    r = (p + 128'h8000) >> 16;
    if (r > (128'd1 << 61)) r = 128'd1 << 61;
    return neg ? -$signed(r[63:0]) : $signed(r[63:0]);
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function void set_span_count(bit [3:0] n);
    span_count = n;
  endfunction

  // note an accepted request beat
  function void note_request(bit qry, bit [3:0] k, logic signed [31:0] t,
                             logic signed [31:0] v [3], logic signed [31:0] s [3]);
    int n;
    logic signed [63:0] t0, t1, h, dl, y0, y1, d0, d1, dy, ca, cb, cc, acc;
    logic [63:0] num;
    logic signed [31:0] r [3];
    if (!qry) begin
      times[k] = t;
      for (int c = 0; c < 3; c++) begin
        vals[k][c] = v[c];
        slps[k][c] = s[c];
      end
      return;
    end
    n = span_count > 15 ? 15 : span_count;
    for (int i = 1; i <= n; i++) begin
      t0 = times[i-1];
      t1 = times[i];
      if (t >= t0 && t <= t1) begin
        if (t == t0) begin
          for (int c = 0; c < 3; c++) r[c] = vals[i-1][c];
        end else begin
          h = t1 - t0;
          num = 64'(t - t0) << 16;
          dl = $signed(num / h);
          for (int c = 0; c < 3; c++) begin
            y0 = vals[i-1][c]; y1 = vals[i][c];
            d0 = slps[i-1][c]; d1 = slps[i][c];
            dy = y0 - y1;
            ca = qmul(h, d0 + d1) + 2 * dy;
            cb = qmul(h, 2 * d0 + d1) + 3 * dy;
            cc = qmul(h, d0);
            acc = qmul(ca, dl) - cb;
            acc = qmul(acc, dl) + cc;
            acc = qmul(acc, dl) + y0;
            r[c] = sat32(acc);
          end
        end
        pending.push_back({r[0], r[1], r[2], 1'b0});
        return;
      end
    end
    pending.push_back({96'd0, 1'b1});
  endfunction

  // compare one result beat with the oldest prediction
  function void check_result(logic [31:0] ra, logic [31:0] rb, logic [31:0] rc,
                             logic st);
    logic [96:0] e;
    if (pending.size() == 0) begin
      $display("%0t unexpected result beat: actual %h %h %h %b", $time, ra, rb, rc, st);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (e[96:65] !== ra || e[64:33] !== rb || e[32:1] !== rc || e[0] !== st) begin
      $display("%0t mismatch: expected %h %h %h %b actual %h %h %h %b", $time,
               e[96:65], e[64:33], e[32:1], e[0], ra, rb, rc, st);
      errors++;
    end
  endfunction
endclass

module tb;
  logic clk = 0, rst = 1;
  logic start = 0, req_type = 0, cfg_we = 0;
  logic [3:0] knot_index = 0, cfg_wdata = 0;
  logic signed [31:0] time_value = 0, value_a = 0, value_b = 0, value_c = 0;
  logic signed [31:0] slope_a = 0, slope_b = 0, slope_c = 0;
  logic busy, done, status;
  logic signed [31:0] result_a, result_b, result_c;

  hermite_scoreboard sb = new();
  int cycle_count = 0;
  bit calm = 0;          // long stretch with no sender gaps
  bit [3:0] active_n = 1;

  hermite_knot_table_interpolator dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // result beats cannot be stalled: sample each one at its edge
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && done) sb.check_result(result_a, result_b, result_c, status);
    if (cycle_count > 400000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($signed($urandom_range(0, 65536 * 8)) - 65536 * 4);
      default: return $urandom;
    endcase
  endfunction

  // one request beat; gaps of about 8 in a hundred unless calm
  // start stays high after the beat so the next send can follow directly
  task automatic send(bit qry, bit [3:0] k, logic [31:0] t,
                      logic [31:0] v0, logic [31:0] v1, logic [31:0] v2,
                      logic [31:0] s0, logic [31:0] s1, logic [31:0] s2);
    logic signed [31:0] v [3];
    logic signed [31:0] s [3];
    while (!calm && $urandom_range(0, 99) < 8) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1; req_type <= qry; knot_index <= k; time_value <= t;
    value_a <= v0; value_b <= v1; value_c <= v2;
    slope_a <= s0; slope_b <= s1; slope_c <= s2;
    @(posedge clk);
    while (busy) @(posedge clk);
    v = '{v0, v1, v2};
    s = '{s0, s1, s2};
    sb.note_request(qry, k, t, v, s);
  endtask

  task automatic write_knot(bit [3:0] k, logic [31:0] t);
    send(0, k, t, rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word());
  endtask

  task automatic query(logic [31:0] t);
    send(1, 4'($urandom), t, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  // wait for the block to drain, then write interval_count
  task automatic set_count(bit [3:0] n);
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    cfg_we <= 1; cfg_wdata <= n;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_span_count(n);
    active_n = n;
  endtask

  // fill all 16 knots with rising times starting at base
  task automatic load_table(logic signed [31:0] base, int max_step);
    logic signed [31:0] t;
    t = base;
    for (int k = 0; k < 16; k++) begin
      write_knot(4'(k), t);
      t = t + $urandom_range(1, max_step);
    end
  endtask

  // a time near a random knot of the scanned range, or a random time
  function automatic logic [31:0] near_time();
    int k;
    k = $urandom_range(0, active_n > 15 ? 15 : active_n);
    case ($urandom_range(0, 3))
      0: return sb.times[k];
      1: return sb.times[k] + $urandom_range(0, 300000);
      2: return sb.times[k] - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: extremes, equal and decreasing knot times
    write_knot(0, 32'h80000000);
    write_knot(1, 32'h7fffffff);
    query(32'h80000000);
    query(32'h7fffffff);
    query(32'h00000000);
    send(0, 0, 0, 32'h7fffffff, 32'h80000000, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    send(0, 1, 32'h00010000, 32'h80000000, 32'h7fffffff, 32'hffffffff,
         32'h80000000, 32'h7fffffff, 32'h80000000);
    query(32'h00008000);
    query(32'h00000001);
    query(32'h0000ffff);
    query(32'h00010001);
    write_knot(1, 0);                 // equal knot times
    query(0);
    query(1);
    write_knot(1, 32'hffff0000);      // decreasing knot times
    query(32'hffff8000);
    set_count(0);                     // nothing scanned
    query(0);
    load_table(32'hfff00000, 200000);
    set_count(15);
    query(sb.times[15]);
    query(sb.times[14] + 5);
    set_count(15);
    // random phases over several interval counts
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: set_count(1);
        1: set_count(15);
        2: set_count(0);
        default: set_count(4'($urandom_range(0, 15)));
      endcase
      calm = (ph == 4);
      if (ph % 3 == 0) load_table($urandom, $urandom_range(2, 600000));
      else load_table(32'($signed($urandom_range(0, 2000000)) - 1000000), 300000);
      for (int j = 0; j < 55; j++) begin
        if ($urandom_range(0, 19) == 0)
          write_knot(4'($urandom_range(0, active_n > 15 ? 15 : active_n)),
                     $urandom_range(0, 9) == 0 ? $urandom : sb.times[$urandom_range(0, 15)]);
        else query(near_time());
      end
    end
    calm = 0;
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
